// File: rtl/qesm_pkg.sv
// ----------------------------------------------------------------------------
// qesm_pkg: shared types and constants of the quadrature edge speed meter
// Request codes, register map, payload structs and controller commands.
// ----------------------------------------------------------------------------
package qesm_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_SAMPLE  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CPR  = 2'd0;
    localparam logic [1:0] REG_GEAR = 2'd1;
    localparam logic [1:0] REG_CIRC = 2'd2;

    localparam logic [15:0] CPR_RESET  = 16'd1;
    localparam logic [15:0] GEAR_RESET = 16'd1;
    localparam logic [19:0] CIRC_RESET = 20'd256;

    // Sixty million microseconds per minute; the Q8 shift is applied separately.
    localparam logic [25:0] RPM_FACTOR = 26'd60000000;
    localparam logic [19:0] US_PER_S   = 20'd1000000;

    // Divider widths: widest dividend, widest divisor, saturating quotient.
    localparam int NUM_W = 72;
    localparam int DEN_W = 64;
    localparam int Q_W   = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_MOTOR,
        OP_WHEEL,
        OP_SPEED,
        OP_TRAVEL
    } t_div_op;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  edge_line;
        logic [63:0] sample_time_us;
        logic [1:0]  left_dir;
        logic [1:0]  right_dir;
    } t_in_item;

    typedef struct packed {
        logic        side;
        logic        has_data;
        logic [1:0]  direction;
        logic [31:0] elapsed_us;
        logic [31:0] tick_count;
        logic [31:0] motor_rpm_q8;
        logic [31:0] wheel_rpm_q8;
        logic [31:0] speed_mm_s_q8;
        logic [31:0] travel_mm_q8;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] cpr;
        logic [15:0] gear;
        logic [19:0] circ;
    } t_cfg;

    typedef struct packed {
        logic    count_edge;
        logic    restart;
        logic    capture;
        logic    mul1;
        logic    mul2;
        logic    res_init;
        logic    div_start;
        logic    div_store;
        logic    side;
        t_div_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic zero;
        logic div_done;
    } t_dp_stat;

endpackage

// File: rtl/qesm_div.sv
// ----------------------------------------------------------------------------
// qesm_div: saturating restoring divider
// One quotient bit per cycle; a quotient of 2^32 or more gives all ones.
// ----------------------------------------------------------------------------
module qesm_div import qesm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quot;

    logic             w_sat;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // If the upper part of the dividend already reaches the divisor, the
    // quotient cannot fit in the result width.
    assign w_sat   = {{(DEN_W - (NUM_W - Q_W)){1'b0}}, i_num[NUM_W-1:Q_W]} >= i_den;
    assign w_trial = {r_rem, r_quot[Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(Q_W - 1);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            if (w_sat) begin
                r_quot <= '1;
            end else begin
                r_rem  <= {{(DEN_W - (NUM_W - Q_W)){1'b0}}, i_num[NUM_W-1:Q_W]};
                r_quot <= i_num[Q_W-1:0];
            end
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quot <= {r_quot[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/qesm_datapath.sv
// ----------------------------------------------------------------------------
// qesm_datapath: counters, snapshots, products and result register
// Executes the commands of the controller and reports zero and divide status.
// ----------------------------------------------------------------------------
module qesm_datapath import qesm_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_dp_stat  o_stat,
    output t_out_item o_result
);

    logic [COUNT_WIDTH-1:0] r_count [4];
    logic [COUNT_WIDTH-1:0] r_saved [4];
    logic [TIME_WIDTH-1:0]  r_last;

    logic [31:0] r_ticks [2];
    logic [31:0] r_elapsed;
    logic [1:0]  r_dir [2];

    logic [47:0] r_ce;
    logic [31:0] r_cg;
    logic [57:0] r_trpm;
    logic [51:0] r_tw;
    logic [63:0] r_cge;
    logic [71:0] r_tws;

    t_out_item   r_out;

    logic [COUNT_WIDTH-1:0] w_sum [2];
    logic [TIME_WIDTH-1:0]  w_now;
    logic [TIME_WIDTH-1:0]  w_diff;
    logic [31:0]            w_elapsed;
    logic [15:0]            w_cpr;
    logic [15:0]            w_gear;
    logic [31:0]            w_t;
    logic [NUM_W-1:0]       w_num;
    logic [DEN_W-1:0]       w_den;
    logic                   w_div_done;
    logic [Q_W-1:0]         w_quot;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            w_sum[s] = (r_count[2*s] - r_saved[2*s]) + (r_count[2*s+1] - r_saved[2*s+1]);
        end
    end

    assign w_now     = i_item.sample_time_us[TIME_WIDTH-1:0];
    assign w_diff    = w_now - r_last;
    assign w_elapsed = (w_diff > TIME_WIDTH'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w_diff[31:0];

    // A divisor register left at zero counts as one.
    assign w_cpr  = (i_cfg.cpr == 16'd0) ? 16'd1 : i_cfg.cpr;
    assign w_gear = (i_cfg.gear == 16'd0) ? 16'd1 : i_cfg.gear;
    assign w_t    = r_ticks[i_cmd.side];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_count[k] <= '0;
                r_saved[k] <= '0;
            end
            r_last <= '0;
        end else if (i_cmd.count_edge) begin
            r_count[i_item.edge_line] <= r_count[i_item.edge_line] + 1'b1;
        end else if (i_cmd.restart) begin
            for (int k = 0; k < 4; k++) begin
                r_count[k] <= '0;
                r_saved[k] <= '0;
            end
            r_last <= w_now;
        end else if (i_cmd.capture) begin
            for (int k = 0; k < 4; k++) begin
                r_saved[k] <= r_count[k];
            end
            r_last <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ticks[0] <= 32'(w_sum[0]);
            r_ticks[1] <= 32'(w_sum[1]);
            r_elapsed  <= w_elapsed;
            r_dir[0]   <= i_item.left_dir;
            r_dir[1]   <= i_item.right_dir;
        end
        if (i_cmd.mul1) begin
            r_ce   <= {32'b0, w_cpr} * {16'b0, r_elapsed};
            r_cg   <= {16'b0, w_cpr} * {16'b0, w_gear};
            r_trpm <= {26'b0, w_t} * {32'b0, RPM_FACTOR};
            r_tw   <= {20'b0, w_t} * {32'b0, i_cfg.circ};
        end
        if (i_cmd.mul2) begin
            r_cge <= {16'b0, r_ce} * {48'b0, w_gear};
            r_tws <= {20'b0, r_tw} * {52'b0, US_PER_S};
        end
    end

    always_comb begin
        case (i_cmd.op)
            OP_MOTOR: begin
                w_num = {6'b0, r_trpm, 8'b0};
                w_den = {16'b0, r_ce};
            end
            OP_WHEEL: begin
                w_num = {6'b0, r_trpm, 8'b0};
                w_den = r_cge;
            end
            OP_SPEED: begin
                w_num = r_tws;
                w_den = r_cge;
            end
            OP_TRAVEL: begin
                w_num = {20'b0, r_tw};
                w_den = {32'b0, r_cg};
            end
            default: begin
                w_num = '0;
                w_den = '1;
            end
        endcase
    end

    qesm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_init) begin
            r_out.side          <= i_cmd.side;
            r_out.has_data      <= (w_t != 32'd0);
            r_out.direction     <= r_dir[i_cmd.side];
            r_out.elapsed_us    <= r_elapsed;
            r_out.tick_count    <= w_t;
            r_out.motor_rpm_q8  <= '0;
            r_out.wheel_rpm_q8  <= '0;
            r_out.speed_mm_s_q8 <= '0;
            r_out.travel_mm_q8  <= '0;
            r_out.last          <= i_cmd.side;
        end else if (i_cmd.div_store) begin
            case (i_cmd.op)
                OP_MOTOR:  r_out.motor_rpm_q8  <= w_quot;
                OP_WHEEL:  r_out.wheel_rpm_q8  <= w_quot;
                OP_SPEED:  r_out.speed_mm_s_q8 <= w_quot;
                OP_TRAVEL: r_out.travel_mm_q8  <= w_quot;
                default:   r_out.travel_mm_q8  <= w_quot;
            endcase
        end
    end

    assign o_stat.zero     = (w_t == 32'd0) || (r_elapsed == 32'd0);
    assign o_stat.div_done = w_div_done;
    assign o_result        = r_out;

endmodule

// File: rtl/qesm_ctrl.sv
// ----------------------------------------------------------------------------
// qesm_ctrl: request sequencer
// Decodes requests and steps each side through multiply, divide and output.
// ----------------------------------------------------------------------------
module qesm_ctrl import qesm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state  r_state, n_state;
    logic    r_side, n_side;
    t_div_op r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side  <= 1'b0;
            r_op    <= OP_MOTOR;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_side      = r_side;
        n_op        = r_op;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.side  = r_side;
        o_cmd.op    = r_op;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_EDGE:    o_cmd.count_edge = 1'b1;
                        REQ_RESTART: o_cmd.restart = 1'b1;
                        REQ_SAMPLE: begin
                            o_cmd.capture = 1'b1;
                            n_side        = 1'b0;
                            n_state       = S_MUL1;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2     = 1'b1;
                o_cmd.res_init = 1'b1;
                n_op           = OP_MOTOR;
                // With no ticks or no time the rates stay zero and no division runs.
                n_state        = i_stat.zero ? S_OUT : S_DIV_START;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    case (r_op)
                        OP_MOTOR: begin
                            n_op    = OP_WHEEL;
                            n_state = S_DIV_START;
                        end
                        OP_WHEEL: begin
                            n_op    = OP_SPEED;
                            n_state = S_DIV_START;
                        end
                        OP_SPEED: begin
                            n_op    = OP_TRAVEL;
                            n_state = S_DIV_START;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_side == 1'b0) begin
                        n_side  = 1'b1;
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/quadrature_edge_speed_meter.sv
// ----------------------------------------------------------------------------
// quadrature_edge_speed_meter: speed from edge counts on two wheel encoders
// Edge and restart requests are accepted back to back while no sample is
// being processed. A sample gives two results, left then right; each side
// passes through the multiply states S_MUL1 and S_MUL2 and four divisions
// (motor rpm, wheel rpm, speed, travel), a saturated division ending early,
// and waits for output ready; with no ticks or no time it skips the divisions.
// Synchronous active-low reset clears counters, snapshots and time and
// restores the register defaults.
// ----------------------------------------------------------------------------
module quadrature_edge_speed_meter import qesm_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg     r_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cpr  <= CPR_RESET;
            r_cfg.gear <= GEAR_RESET;
            r_cfg.circ <= CIRC_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CPR:  r_cfg.cpr  <= pwdata[15:0];
                REG_GEAR: r_cfg.gear <= pwdata[15:0];
                REG_CIRC: r_cfg.circ <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CPR:  prdata = {16'b0, r_cfg.cpr};
            REG_GEAR: prdata = {16'b0, r_cfg.gear};
            REG_CIRC: prdata = {12'b0, r_cfg.circ};
            default:  prdata = 32'b0;
        endcase
    end

    qesm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_data.req_type),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    qesm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_stat   (w_stat),
        .o_result (o_out_data)
    );

endmodule
